>>> hw/rtl/keyboard_scancode_decoder_core_macros.svh
// Assertion macros shared by the keyboard scan code decoder RTL.
`ifndef KEYBOARD_SCANCODE_DECODER_CORE_MACROS_SVH
`define KEYBOARD_SCANCODE_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge outside reset.
`define KSD_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define KSD_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define KSD_ASSERT(lbl, clk, rst_n, cond, msg)
`define KSD_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)

`endif

`endif

>>> hw/rtl/ksd_pkg.sv
// Package with constants, types and character tables of the scan code decoder.
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

    // Command queue depth in bytes; a power of two, split into even and odd banks.
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int BANK_DEPTH  = QUEUE_DEPTH / 2;
    localparam int BANK_W      = PTR_W - 1;

    localparam logic [7:0] LED_CMD     = 8'hED;
    localparam logic [7:0] ACK_BYTE    = 8'hFA;
    localparam logic [7:0] RESEND_BYTE = 8'hFE;
    localparam logic [7:0] MK_LSHIFT   = 8'h2A;
    localparam logic [7:0] MK_RSHIFT   = 8'h36;
    localparam logic [7:0] BRK_LSHIFT  = 8'hAA;
    localparam logic [7:0] BRK_RSHIFT  = 8'hB6;
    localparam logic [7:0] MK_CAPS     = 8'h3A;
    localparam logic [7:0] MK_NUM      = 8'h45;
    localparam logic [7:0] MK_SCROLL   = 8'h46;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [2:0] LED_CAPS   = 3'b100;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b001;

    localparam logic [1:0] SHIFT_LEFT  = 2'b01;
    localparam logic [1:0] SHIFT_RIGHT = 2'b10;

    // Output kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    // Register index carried by paddr[2].
    localparam logic REG_INITIAL_LEDS = 1'b0;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] shift_next;
        logic [2:0] led_mask;
        logic       is_ack;
        logic       is_resend;
    } dec_t;

    typedef struct packed {
        logic       push_pair;
        logic [7:0] led_byte;
        logic       pop;
    } q_req_t;

    localparam logic [7:0] ROM_PLAIN [0:127] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h40, 8'h5B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
    };

    localparam logic [7:0] ROM_SHIFTED [0:127] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h60, 8'h7B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
        8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
    };

endpackage

`default_nettype wire

>>> hw/rtl/keyboard_scancode_decoder_core.sv
// Top level of the PS/2 set-1 keyboard scan code decoder with LED command sender.
//
// The core takes one scan code beat per clock while s_tready is high, and gives at most
// one result beat per scan code: a character (tuser 0) or a byte for the keyboard
// (tuser 1). A result is held in the second-stage register and then in the output
// register before it is shown on the master side; a stalled master side holds one
// result in the output register while the next scan code is decoded. The LED command
// queue sits in two RAM banks of half the queue depth each (even and odd slots), so
// both bytes of a lock key command are written in the same cycle; the popped byte
// comes out of the registered RAM read port in the cycle after the pop, and a resend
// in the very next beat picks it up by forwarding. No clearing pass runs after reset:
// the LED byte queued at reset is held in a register. initial_leds sits at address 0.
`timescale 1ns / 1ps
`default_nettype none

`include "keyboard_scancode_decoder_core_macros.svh"

module keyboard_scancode_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Scan code input
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] scan_code
    // Result output
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // [7:0] value
    output      logic        m_tuser,   // [0] kind
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic          accept;
    logic          cfg_we;
    ksd_pkg::dec_t dec;
    ksd_pkg::q_req_t q_req;
    logic          can_pop;
    logic [7:0]    head_byte;

    logic [2:0]    initial_leds_reg;
    logic [1:0]    shift_held_reg;
    logic [2:0]    lock_leds_reg;
    logic [2:0]    lock_leds_next;
    logic          awaiting_reg;
    logic          awaiting_after;
    logic [7:0]    in_flight_reg;
    logic [7:0]    in_flight_now;
    logic          fresh_reg;

    logic          resend_out;
    logic          char_out;
    logic          pop;

    logic          s2_valid_reg;
    logic          s2_res_reg;
    logic          s2_kind_reg;
    logic          s2_pop_reg;
    logic [7:0]    s2_value_reg;
    logic          s2_go;
    logic          out_load;

    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [7:0]    out_value_reg;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == ksd_pkg::REG_INITIAL_LEDS);
    assign prdata = (paddr[2] == ksd_pkg::REG_INITIAL_LEDS) ? {29'b0, initial_leds_reg} : 32'b0;

    ksd_decode u_decode (
        .code       (s_tdata),
        .shift_held (shift_held_reg),
        .caps       (lock_leds_reg[2]),
        .dec        (dec)
    );

    // A byte popped by the previous beat is still on its way out of the RAM.
    assign in_flight_now = (s2_valid_reg && s2_pop_reg) ? head_byte : in_flight_reg;

    assign accept         = s_tvalid && s_tready;
    assign lock_leds_next = lock_leds_reg ^ dec.led_mask;
    assign awaiting_after = dec.is_ack ? 1'b0 : awaiting_reg;
    assign resend_out     = dec.is_resend && awaiting_reg;
    assign char_out       = !resend_out && (dec.ch != 8'h00);
    assign pop            = accept && !resend_out && !char_out && !awaiting_after && can_pop;

    assign q_req.push_pair = accept && (dec.led_mask != 3'b000);
    assign q_req.led_byte  = {5'b0, lock_leds_next};
    assign q_req.pop       = pop;

    ksd_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (cfg_we && fresh_reg),
        .seed      (pwdata[2:0]),
        .req       (q_req),
        .can_pop   (can_pop),
        .head_byte (head_byte)
    );

    assign s2_go    = !out_valid_reg || m_tready;
    assign s_tready = !s2_valid_reg || !s2_res_reg || s2_go;
    assign out_load = s2_valid_reg && s2_res_reg && s2_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_leds_reg <= '0;
            shift_held_reg   <= '0;
            lock_leds_reg    <= '0;
            awaiting_reg     <= 1'b1;
            in_flight_reg    <= ksd_pkg::LED_CMD;
            fresh_reg        <= 1'b1;
            s2_valid_reg     <= 1'b0;
            s2_res_reg       <= 1'b0;
            s2_pop_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                initial_leds_reg <= pwdata[2:0];
                if (fresh_reg)
                begin
                    lock_leds_reg <= pwdata[2:0];
                end
            end
            if (s2_valid_reg && s2_pop_reg)
            begin
                in_flight_reg <= head_byte;
            end
            if (accept)
            begin
                fresh_reg      <= 1'b0;
                shift_held_reg <= dec.shift_next;
                lock_leds_reg  <= lock_leds_next;
                awaiting_reg   <= pop ? 1'b1 : awaiting_after;
                s2_valid_reg   <= 1'b1;
                s2_res_reg     <= resend_out || char_out || pop;
                s2_pop_reg     <= pop;
            end
            else if (s_tready)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_kind_reg  <= char_out ? ksd_pkg::KIND_CHAR : ksd_pkg::KIND_SEND;
            s2_value_reg <= resend_out ? in_flight_now : dec.ch;
        end
        if (out_load)
        begin
            out_kind_reg  <= s2_kind_reg;
            out_value_reg <= s2_pop_reg ? head_byte : s2_value_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_value_reg;

    // The input side only stalls behind a full output register.
    `KSD_ASSERT(a_stall_needs_full_out, clk, rst_n, s_tready || m_tvalid, "input stalled with output empty")
    // A popped byte is always a pending keyboard send.
    `KSD_ASSERT(a_pop_is_send, clk, rst_n, !(s2_valid_reg && s2_pop_reg) || (s2_res_reg && (s2_kind_reg == ksd_pkg::KIND_SEND)), "popped byte not marked as send")
    // While a popped byte waits in the second stage it is in flight.
    `KSD_ASSERT(a_pop_in_flight, clk, rst_n, !(s2_valid_reg && s2_pop_reg) || awaiting_reg, "popped byte not awaiting ack")
    // A result loaded into the output register is shown in the next cycle.
    `KSD_ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, m_tvalid, "loaded result not shown")

endmodule

`default_nettype wire

>>> hw/rtl/ksd_ram.sv
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ksd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Read data holds until the next read.
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ksd_decode.sv
// Scan code decode: character lookup, shift tracking and lock key detection.
`timescale 1ns / 1ps
`default_nettype none

module ksd_decode (
    input  wire logic [7:0]    code,
    input  wire logic [1:0]    shift_held,
    input  wire logic          caps,
    output      ksd_pkg::dec_t dec
);

    logic       shifted;
    logic [7:0] base;
    logic       is_letter;

    assign shifted   = |shift_held;
    assign base      = code[7] ? 8'h00 :
                       (shifted ? ksd_pkg::ROM_SHIFTED[code[6:0]] : ksd_pkg::ROM_PLAIN[code[6:0]]);
    assign is_letter = (base >= ksd_pkg::CHAR_UPPER_A) && (base <= ksd_pkg::CHAR_UPPER_Z);

    always_comb
    begin
        dec            = '0;
        // Letters come out lowercase unless exactly one of caps lock and shift is active.
        dec.ch         = (is_letter && (caps == shifted)) ? base + ksd_pkg::CASE_OFFSET : base;
        dec.shift_next = shift_held;
        case (code)
            ksd_pkg::MK_LSHIFT:   dec.shift_next = shift_held | ksd_pkg::SHIFT_LEFT;
            ksd_pkg::MK_RSHIFT:   dec.shift_next = shift_held | ksd_pkg::SHIFT_RIGHT;
            ksd_pkg::BRK_LSHIFT:  dec.shift_next = shift_held & ksd_pkg::SHIFT_RIGHT;
            ksd_pkg::BRK_RSHIFT:  dec.shift_next = shift_held & ksd_pkg::SHIFT_LEFT;
            ksd_pkg::MK_CAPS:     dec.led_mask   = ksd_pkg::LED_CAPS;
            ksd_pkg::MK_NUM:      dec.led_mask   = ksd_pkg::LED_NUM;
            ksd_pkg::MK_SCROLL:   dec.led_mask   = ksd_pkg::LED_SCROLL;
            ksd_pkg::ACK_BYTE:    dec.is_ack     = 1'b1;
            ksd_pkg::RESEND_BYTE: dec.is_resend  = 1'b1;
            default:              dec.is_ack     = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ksd_cmd_queue.sv
// Keyboard command byte queue held in an even and an odd RAM bank.
`timescale 1ns / 1ps
`default_nettype none

module ksd_cmd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            seed_we,
    input  wire logic [2:0]      seed,
    input  wire ksd_pkg::q_req_t req,
    output      logic            can_pop,
    output      logic [7:0]      head_byte
);

    localparam int PTR_W = ksd_pkg::PTR_W;
    localparam int CNT_W = ksd_pkg::CNT_W;
    localparam int BANK_W = ksd_pkg::BANK_W;

    logic [PTR_W-1:0] rp_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cnt1;
    logic [CNT_W-1:0] cnt2;
    logic             pending0_reg;
    logic [2:0]       seed_reg;
    logic             head_sel_reg;
    logic             head_fwd_reg;
    logic             head_ovr_reg;
    logic             push1_ok;
    logic             push2_ok;
    logic [PTR_W-1:0] slot1;
    logic [PTR_W-1:0] slot2;
    logic [7:0]       rdata [0:1];

    assign push1_ok = req.push_pair && (count_reg != CNT_W'(ksd_pkg::QUEUE_DEPTH));
    assign cnt1     = count_reg + CNT_W'(push1_ok);
    assign push2_ok = push1_ok && (cnt1 != CNT_W'(ksd_pkg::QUEUE_DEPTH));
    assign cnt2     = cnt1 + CNT_W'(push2_ok);
    assign can_pop  = (cnt2 != '0);
    assign slot1    = rp_reg + count_reg[PTR_W-1:0];
    assign slot2    = slot1 + PTR_W'(1);

    // The two bytes of an LED command land in adjacent slots, hence in different banks.
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        logic             bank_we;
        logic [BANK_W-1:0] bank_waddr;
        logic [7:0]       bank_wdata;
        logic             first_here;

        assign first_here = (slot1[0] == 1'(b));
        assign bank_we    = first_here ? push1_ok : push2_ok;
        assign bank_waddr = first_here ? slot1[PTR_W-1:1] : slot2[PTR_W-1:1];
        assign bank_wdata = first_here ? ksd_pkg::LED_CMD : req.led_byte;

        ksd_ram #(
            .WIDTH (8),
            .DEPTH (ksd_pkg::BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we),
            .waddr (bank_waddr),
            .wdata (bank_wdata),
            .re    (req.pop),
            .raddr (rp_reg[PTR_W-1:1]),
            .rdata (rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            count_reg    <= CNT_W'(1);
            pending0_reg <= 1'b1;
            seed_reg     <= '0;
            head_sel_reg <= 1'b0;
            head_fwd_reg <= 1'b0;
            head_ovr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= cnt2 - CNT_W'(req.pop);
            if (seed_we)
            begin
                seed_reg <= seed;
            end
            if (req.pop)
            begin
                rp_reg       <= rp_reg + PTR_W'(1);
                head_sel_reg <= rp_reg[0];
                // An empty queue that takes an LED command pops the 0xED it just wrote.
                head_fwd_reg <= push1_ok && (count_reg == '0);
                // The first entry after reset lives in a register, not in the RAM.
                head_ovr_reg <= pending0_reg;
                pending0_reg <= 1'b0;
            end
        end
    end

    assign head_byte = head_ovr_reg ? {5'b0, seed_reg} :
                       head_fwd_reg ? ksd_pkg::LED_CMD :
                       rdata[head_sel_reg];

endmodule

`default_nettype wire
